/* design/brf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants for the byte ring FIFO
// Storage depth, index and count widths, request kinds, controller states, control bundle.
// ----------------------------------------------------------------------------
package brf_pkg;

	localparam int DEPTH  = 256;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;

	// request kinds; code 3 is unused and acts as a no-op
	typedef enum logic [KIND_W-1:0] {
		REQ_PUSH = 2'd0,
		REQ_POP  = 2'd1,
		REQ_PEEK = 2'd2
	} req_kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SEND = 1'b1
	} brf_state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;     // request accepted this cycle
	} brf_cmd_t;

endpackage

/* design/brf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_ctrl: request/result handshake controller
// Tracks whether a result is held and issues the take command.
// ----------------------------------------------------------------------------
module brf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output brf_pkg::brf_cmd_t cmd
);
	import brf_pkg::*;

	brf_state_t state_q;
	brf_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		m_tvalid     = 1'b0;
		cmd.take     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				m_tvalid     = 1'b1;
				// slot frees as the result leaves, so a new request may enter
				s_tready     = m_tready;
				cmd.take     = s_tvalid && m_tready;
				if (m_tready && !s_tvalid) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* design/brf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_datapath: ring storage, pointers, fill count and result register
// Evaluates one request per take command; memory read data is registered.
// ----------------------------------------------------------------------------
module brf_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  brf_pkg::brf_cmd_t              cmd,
	input  logic                           cfg_we,
	input  logic [brf_pkg::CNT_W-1:0]      cfg_wdata,
	input  logic [brf_pkg::KIND_W-1:0]     req_type,
	input  logic [brf_pkg::BYTE_W-1:0]     push_byte,
	input  logic [brf_pkg::BYTE_W-1:0]     peek_offset,
	output logic                           ok,
	output logic [brf_pkg::BYTE_W-1:0]     read_byte,
	output logic [brf_pkg::CNT_W-1:0]      fill_count,
	output logic                           is_empty,
	output logic                           is_full
);
	import brf_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	logic [CNT_W-1:0] size_q;
	logic [IDX_W-1:0] wr_q;
	logic [IDX_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	// result register
	logic              ok_q;
	logic              byte_sel_q;
	logic [BYTE_W-1:0] rdata_q;
	logic [CNT_W-1:0]  fill_q;
	logic              empty_q;
	logic              full_q;

	logic [CNT_W-1:0] size_eff;
	logic             full_now;
	logic             push_ok;
	logic             pop_ok;
	logic             peek_ok;
	logic [CNT_W-1:0] wr_inc;
	logic [CNT_W-1:0] rd_inc;
	logic [IDX_W-1:0] wr_next;
	logic [IDX_W-1:0] rd_next;
	logic [CNT_W-1:0] peek_sum;
	logic [CNT_W-1:0] peek_pos;
	logic [CNT_W-1:0] count_next;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;

	always_comb begin
		size_eff = (size_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : size_q;
		full_now = count_q >= size_eff;
		push_ok  = 1'b0;
		pop_ok   = 1'b0;
		peek_ok  = 1'b0;
		case (req_kind_t'(req_type))
			REQ_PUSH: push_ok = !full_now && (size_eff != '0);
			REQ_POP:  pop_ok  = (count_q != '0) && (size_eff != '0);
			REQ_PEEK: peek_ok = (CNT_W'(peek_offset) < count_q) && (size_eff != '0);
			default:  ;
		endcase

		wr_inc  = CNT_W'(wr_q) + CNT_W'(1);
		rd_inc  = CNT_W'(rd_q) + CNT_W'(1);
		wr_next = (wr_inc >= size_eff) ? '0 : wr_inc[IDX_W-1:0];
		rd_next = (rd_inc >= size_eff) ? '0 : rd_inc[IDX_W-1:0];

		// offset < count <= size, so one conditional subtract wraps it
		peek_sum = CNT_W'(rd_q) + CNT_W'(peek_offset);
		peek_pos = (peek_sum >= size_eff) ? (peek_sum - size_eff) : peek_sum;

		count_next = count_q;
		if (push_ok) begin
			count_next = count_q + CNT_W'(1);
		end else if (pop_ok) begin
			count_next = count_q - CNT_W'(1);
		end

		rd_en   = pop_ok || peek_ok;
		rd_addr = peek_ok ? peek_pos[IDX_W-1:0] : rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= CNT_W'(DEPTH);
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			size_q  <= cfg_wdata;
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else if (cmd.take) begin
			if (push_ok) begin
				wr_q <= wr_next;
			end
			if (pop_ok) begin
				rd_q <= rd_next;
			end
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && push_ok) begin
			mem[wr_q] <= push_byte;
		end
		if (cmd.take && rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			ok_q       <= push_ok || pop_ok || peek_ok;
			byte_sel_q <= rd_en;
			fill_q     <= count_next;
			empty_q    <= (count_next == '0);
			full_q     <= (count_next >= size_eff);
		end
	end

	assign ok         = ok_q;
	assign read_byte  = byte_sel_q ? rdata_q : '0;
	assign fill_count = fill_q;
	assign is_empty   = empty_q;
	assign is_full    = full_q;

endmodule

/* design/byte_ring_fifo_with_peek.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_peek: byte circular FIFO with fill count and peek
// Push, pop or peek-at-offset requests in, one status result per request out.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_* stream: s_tuser carries the request kind
//   (push, pop, peek), s_tdata the push byte and the peek offset.
//   Every request yields exactly one result on the m_* stream: success flag,
//   read byte, fill count after the request, empty and full flags.
//   cfg_we/cfg_wdata set the ring size in use (1..256, larger saturates to
//   256, zero makes every request fail); a write also empties the ring.
//   Write it only while no request is in flight.
// Result timing and throughput:
//   A result appears in the cycle after its request is taken (memory read
//   data is registered). The result register holds one entry; a new
//   request is taken in the same cycle the held result leaves, so with the
//   receiver always ready the block sustains one request per clock.
// Reset:
//   arst_n clears the pointers and count and restores a ring size of 256.
//   Storage contents are not cleared; nothing reads an unwritten entry.
// Backpressure:
//   While a result is held and m_tready is low, it holds and s_tready stays low.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_peek (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,   // ring_size
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [7:0] push_byte, [15:8] peek_offset
	input  logic [1:0]  s_tuser,     // [1:0] req_type
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata      // [0] ok, [8:1] read_byte, [17:9] fill_count,
	                                 // [18] is_empty, [19] is_full, [23:20] zero
);
	import brf_pkg::*;

	brf_cmd_t          cmd;
	logic              res_ok;
	logic [BYTE_W-1:0] res_byte;
	logic [CNT_W-1:0]  res_fill;
	logic              res_empty;
	logic              res_full;

	// handshake sequencing
	brf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// storage, pointers, count, result register
	brf_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req_type    (s_tuser),
		.push_byte   (s_tdata[7:0]),
		.peek_offset (s_tdata[15:8]),
		.ok          (res_ok),
		.read_byte   (res_byte),
		.fill_count  (res_fill),
		.is_empty    (res_empty),
		.is_full     (res_full)
	);

	assign m_tdata = {4'b0000, res_full, res_empty, res_fill, res_byte, res_ok};

`ifndef ASSERT_OFF
	// fill count never exceeds the storage depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_fill <= CNT_W'(DEPTH)))
		else $error("fill count above depth");

	// empty flag agrees with the count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_empty == (res_fill == '0)))
		else $error("empty flag mismatch");

	// a failed request returns a zero byte
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !res_ok) |-> (res_byte == '0))
		else $error("nonzero byte on failed request");

	// with no result held the block must be open for a request
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request stalled with no result pending");

	// a taken request always produces a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> m_tvalid)
		else $error("request taken without result");
`endif

endmodule
